// ===== rtl/wae_pkg.sv =====
// Shared types, codes and constants for the weighted automaton word evaluator.
package wae_pkg;

   localparam int DEF_MAX_STATES  = 8;
   localparam int DEF_MAX_LETTERS = 16;
   localparam int DEF_WEIGHT_BITS = 32;

   localparam int WEIGHT_W      = 32;
   localparam int FRAC_BITS     = 16;
   localparam int PROD_W        = 2 * WEIGHT_W;
   localparam int PIPE_LAT      = 3;
   localparam int DRAIN_W       = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int STATE_COUNT_W = 4;
   localparam int ALPHABET_W    = 5;
   localparam int INDEX_W       = 3;
   localparam int LETTER_W      = 4;

   localparam logic [STATE_COUNT_W-1:0] RST_STATE_COUNT   = 4'd8;
   localparam logic [ALPHABET_W-1:0]    RST_ALPHABET_SIZE = 5'd16;

   typedef enum logic [2:0] {
      ACT_LOAD_START  = 3'd0,
      ACT_LOAD_END    = 3'd1,
      ACT_LOAD_MATRIX = 3'd2,
      ACT_LETTER      = 3'd3,
      ACT_EMPTY_WORD  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LETTER = 2'd1,
      STATUS_SATURATED  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_STATE_COUNT   = 1'b0,
      REG_ALPHABET_SIZE = 1'b1
   } csr_reg_type;

   typedef struct packed {
      action_type                  action;
      logic [INDEX_W-1:0]          row_index;
      logic [INDEX_W-1:0]          col_index;
      logic [LETTER_W-1:0]         letter;
      logic signed [WEIGHT_W-1:0]  weight;
      logic                        word_start;
      logic                        word_end;
   } req_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0]  score;
      status_type                  status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MAT_ISSUE,
      ST_MAT_DRAIN,
      ST_FINISH,
      ST_DOT_ISSUE,
      ST_DOT_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic word_begin;
      logic mark_fail;
      logic clear_dest;
      logic swap;
      logic issue;
      logic first;
      logic last;
      logic mode_dot;
      logic vec_start;
      logic use_seen;
      logic emit_fail;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       letter_ok;
      logic       word_failed;
      logic       word_start;
      logic       word_end;
   } dp_status_type;

endpackage

// ===== rtl/weighted_automaton_word_eval_top.sv =====
// Top level of the weighted automaton word evaluator.
// One beat is taken when start is high and busy is low; busy stays high until the beat's
// work is done. With n active states a valid letter of a live word makes n*n
// multiply-accumulates, a letter that ends a word n more, and the empty word n; they run
// one per cycle through the single shared multiplier. A result appears on rsp_data for
// exactly one cycle with rsp_strobe high and cannot be held off by the receiver.
module weighted_automaton_word_eval_top import wae_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_LETTERS = DEF_MAX_LETTERS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int CNT_W = $clog2(MAX_STATES + 1);
   localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

   logic [CNT_W-1:0]      n_states;
   logic [ALPHABET_W-1:0] alphabet_size;
   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic [IDX_W-1:0]      row_idx;
   logic [IDX_W-1:0]      col_idx;

   wae_csr #(
      .MAX_STATES (MAX_STATES)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .n_states      (n_states),
      .alphabet_size (alphabet_size)
   );

   wae_ctrl #(
      .MAX_STATES (MAX_STATES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .n_states (n_states),
      .status   (status),
      .cmd      (cmd),
      .row_idx  (row_idx),
      .col_idx  (col_idx)
   );

   wae_dp #(
      .MAX_STATES  (MAX_STATES),
      .MAX_LETTERS (MAX_LETTERS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .cmd           (cmd),
      .row_idx       (row_idx),
      .col_idx       (col_idx),
      .alphabet_size (alphabet_size),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== rtl/wae_csr.sv =====
// Configuration registers on the APB-style port, with derived active state count.
module wae_csr import wae_pkg::*; #(
   parameter int MAX_STATES = DEF_MAX_STATES,
   localparam int CNT_W = $clog2(MAX_STATES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [CNT_W-1:0]        n_states,
   output logic [ALPHABET_W-1:0]   alphabet_size
);

   logic [STATE_COUNT_W-1:0] state_count_ff, state_count_in;
   logic [ALPHABET_W-1:0]    alphabet_size_ff, alphabet_size_in;
   csr_reg_type              reg_sel;

   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1]);
   assign pready  = 1'b1;

   always_comb begin
      state_count_in   = state_count_ff;
      alphabet_size_in = alphabet_size_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_STATE_COUNT:   state_count_in   = pwdata[STATE_COUNT_W-1:0];
            REG_ALPHABET_SIZE: alphabet_size_in = pwdata[ALPHABET_W-1:0];
            default:           state_count_in   = state_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff   <= RST_STATE_COUNT;
         alphabet_size_ff <= RST_ALPHABET_SIZE;
      end else begin
         state_count_ff   <= state_count_in;
         alphabet_size_ff <= alphabet_size_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_STATE_COUNT:   prdata = CSR_DATA_W'(state_count_ff);
         REG_ALPHABET_SIZE: prdata = CSR_DATA_W'(alphabet_size_ff);
         default:           prdata = '0;
      endcase
   end

   // zero counts as one state, large counts clip to the storage size
   always_comb begin
      if (state_count_ff == '0) begin
         n_states = CNT_W'(1);
      end else if (int'(state_count_ff) > MAX_STATES) begin
         n_states = CNT_W'(MAX_STATES);
      end else begin
         n_states = CNT_W'(state_count_ff);
      end
   end

   assign alphabet_size = alphabet_size_ff;

endmodule

// ===== rtl/wae_ctrl.sv =====
// Sequencer: decodes each beat and steps the multiply-accumulate passes.
module wae_ctrl import wae_pkg::*; #(
   parameter int MAX_STATES = DEF_MAX_STATES,
   localparam int CNT_W = $clog2(MAX_STATES + 1),
   localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CNT_W-1:0]  n_states,
   input  dp_status_type     status,
   output ctrl_cmd_type      cmd,
   output logic [IDX_W-1:0]  row_idx,
   output logic [IDX_W-1:0]  col_idx
);

   ctrl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [DRAIN_W-1:0]   drain_ff, drain_in;
   logic                 i_last, j_last, drain_done, is_empty;

   assign i_last     = (i_ff == n_states - CNT_W'(1));
   assign j_last     = (j_ff == n_states - CNT_W'(1));
   assign drain_done = (drain_ff == DRAIN_W'(PIPE_LAT - 1));
   assign is_empty   = (status.action == ACT_EMPTY_WORD);
   assign row_idx    = i_ff[IDX_W-1:0];
   assign col_idx    = j_ff[IDX_W-1:0];
   assign busy       = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         drain_ff <= drain_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      drain_in = drain_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            i_in = '0;
            j_in = '0;
            unique case (status.action) inside
               ACT_LOAD_START, ACT_LOAD_END, ACT_LOAD_MATRIX: begin
                  cmd.load = 1'b1;
                  state_in = ST_IDLE;
               end
               ACT_EMPTY_WORD: begin
                  state_in = ST_DOT_ISSUE;
               end
               ACT_LETTER: begin
                  cmd.word_begin = status.word_start;
                  if (!status.letter_ok) begin
                     cmd.mark_fail = 1'b1;
                     state_in      = ST_FINISH;
                  end else if (!status.word_start && status.word_failed) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.clear_dest = 1'b1;
                     state_in       = ST_MAT_ISSUE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MAT_ISSUE: begin
            cmd.issue     = 1'b1;
            cmd.first     = (i_ff == '0);
            cmd.last      = i_last;
            cmd.vec_start = status.word_start;
            if (i_last) begin
               i_in = '0;
               j_in = j_ff + CNT_W'(1);
               if (j_last) begin
                  drain_in = '0;
                  state_in = ST_MAT_DRAIN;
               end
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_MAT_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_done) begin
               cmd.swap = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            i_in = '0;
            j_in = '0;
            if (!status.word_end) begin
               state_in = ST_IDLE;
            end else if (status.word_failed) begin
               cmd.emit_fail = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_DOT_ISSUE;
            end
         end
         ST_DOT_ISSUE: begin
            cmd.issue     = 1'b1;
            cmd.mode_dot  = 1'b1;
            cmd.first     = (i_ff == '0);
            cmd.last      = i_last;
            cmd.vec_start = is_empty;
            cmd.use_seen  = !is_empty;
            i_in          = i_ff + CNT_W'(1);
            if (i_last) begin
               drain_in = '0;
               state_in = ST_DOT_DRAIN;
            end
         end
         ST_DOT_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/wae_dp.sv =====
// Datapath: weight stores, shared multiplier, exact accumulator, clamp and result register.
module wae_dp import wae_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_LETTERS = DEF_MAX_LETTERS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   localparam int CNT_W = $clog2(MAX_STATES + 1),
   localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   input  ctrl_cmd_type           cmd,
   input  logic [IDX_W-1:0]       row_idx,
   input  logic [IDX_W-1:0]       col_idx,
   input  logic [ALPHABET_W-1:0]  alphabet_size,
   output dp_status_type          status,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data
);

   localparam int LET_W      = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
   localparam int ACC_W      = PROD_W + CNT_W;
   localparam int EFF_BITS   = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int TRANS_AW   = LET_W + 2 * IDX_W;
   localparam int VEC_DEPTH  = 2 ** IDX_W;
   localparam int RUN_DEPTH  = 2 * VEC_DEPTH;
   localparam int RUN_AW     = IDX_W + 1;

   localparam logic signed [WEIGHT_W-1:0] LD_MAX =
      WEIGHT_W'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
   localparam logic signed [WEIGHT_W-1:0] LD_MIN = -LD_MAX - 1;
   localparam logic signed [ACC_W-1:0] RES_MAX =
      ACC_W'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] RES_MIN = -RES_MAX - 1;

   req_type item_ff;

   logic [WEIGHT_W-1:0] trans_mem [2**TRANS_AW];
   logic [WEIGHT_W-1:0] start_mem [VEC_DEPTH];
   logic [WEIGHT_W-1:0] end_mem   [VEC_DEPTH];
   logic [WEIGHT_W-1:0] run_mem   [RUN_DEPTH];

   logic [VEC_DEPTH-1:0] start_vld_ff;
   logic [VEC_DEPTH-1:0] end_vld_ff;
   logic [RUN_DEPTH-1:0] run_vld_ff;

   logic bank_ff, word_failed_ff, sat_seen_ff;

   logic signed [WEIGHT_W-1:0] ld_val;
   logic [IDX_W-1:0]           ld_row;
   logic                       row_ok, col_ok, let_ok;
   logic                       start_we, end_we, trans_we, run_we;
   logic [TRANS_AW-1:0]        trans_waddr, trans_raddr;
   logic [RUN_AW-1:0]          run_waddr, run_raddr;

   // stage 1: registered memory reads
   logic [WEIGHT_W-1:0] start_q_ff, end_q_ff, trans_q_ff, run_q_ff;
   logic                start_v_ff, end_v_ff, run_v_ff;
   logic                s1_valid_ff, s1_first_ff, s1_last_ff, s1_dot_ff;
   logic                s1_vec_start_ff, s1_use_seen_ff;
   logic [IDX_W-1:0]    s1_col_ff;
   logic signed [WEIGHT_W-1:0] op_a, op_b;

   // stage 2: product
   logic signed [PROD_W-1:0] prod_ff;
   logic                     s2_valid_ff, s2_first_ff, s2_last_ff, s2_dot_ff, s2_use_seen_ff;
   logic [IDX_W-1:0]         s2_col_ff;

   // stage 3: accumulator
   logic signed [ACC_W-1:0]  acc_ff, acc_base, acc_shift;
   logic                     s3_wb_ff, s3_dot_ff, s3_use_seen_ff;
   logic [IDX_W-1:0]         s3_col_ff;
   logic signed [WEIGHT_W-1:0] res_val;
   logic                       res_sat;

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;

   // load path
   assign row_ok = int'(item_ff.row_index) < MAX_STATES;
   assign col_ok = int'(item_ff.col_index) < MAX_STATES;
   assign let_ok = int'(item_ff.letter) < MAX_LETTERS;
   assign ld_row = IDX_W'(item_ff.row_index);

   always_comb begin
      if (item_ff.weight > LD_MAX) begin
         ld_val = LD_MAX;
      end else if (item_ff.weight < LD_MIN) begin
         ld_val = LD_MIN;
      end else begin
         ld_val = item_ff.weight;
      end
   end

   assign start_we = cmd.load && (item_ff.action == ACT_LOAD_START) && row_ok;
   assign end_we   = cmd.load && (item_ff.action == ACT_LOAD_END) && row_ok;
   assign trans_we = cmd.load && (item_ff.action == ACT_LOAD_MATRIX)
                     && row_ok && col_ok && let_ok;

   assign trans_waddr = {LET_W'(item_ff.letter), ld_row, IDX_W'(item_ff.col_index)};
   assign trans_raddr = {LET_W'(item_ff.letter), row_idx, col_idx};
   assign run_raddr   = {bank_ff, row_idx};
   assign run_waddr   = {~bank_ff, s3_col_ff};
   assign run_we      = s3_wb_ff && !s3_dot_ff;

   assign status.action      = item_ff.action;
   assign status.letter_ok   = ({1'b0, item_ff.letter} < alphabet_size) && let_ok;
   assign status.word_failed = word_failed_ff;
   assign status.word_start  = item_ff.word_start;
   assign status.word_end    = item_ff.word_end;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_waddr] <= ld_val;
      end
      trans_q_ff <= trans_mem[trans_raddr];
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[ld_row] <= ld_val;
      end
      start_q_ff <= start_mem[row_idx];
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[ld_row] <= ld_val;
      end
      end_q_ff <= end_mem[row_idx];
   end

   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= res_val;
      end
      run_q_ff <= run_mem[run_raddr];
   end

   // start and end entries never written read as zero, as do running entries not written since their bank was cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         start_vld_ff <= '0;
         end_vld_ff   <= '0;
         run_vld_ff   <= '0;
      end else begin
         if (start_we) begin
            start_vld_ff[ld_row] <= 1'b1;
         end
         if (end_we) begin
            end_vld_ff[ld_row] <= 1'b1;
         end
         if (cmd.clear_dest) begin
            for (int k = 0; k < VEC_DEPTH; k++) begin
               run_vld_ff[{~bank_ff, IDX_W'(k)}] <= 1'b0;
            end
         end
         if (run_we) begin
            run_vld_ff[run_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_v_ff      <= start_vld_ff[row_idx];
      end_v_ff        <= end_vld_ff[row_idx];
      run_v_ff        <= run_vld_ff[run_raddr];
      s1_first_ff     <= cmd.first;
      s1_last_ff      <= cmd.last;
      s1_dot_ff       <= cmd.mode_dot;
      s1_vec_start_ff <= cmd.vec_start;
      s1_use_seen_ff  <= cmd.use_seen;
      s1_col_ff       <= col_idx;
   end

   assign op_a = s1_vec_start_ff ? (start_v_ff ? start_q_ff : '0)
                                 : (run_v_ff ? run_q_ff : '0);
   assign op_b = s1_dot_ff ? (end_v_ff ? end_q_ff : '0) : trans_q_ff;

   always_ff @(posedge clock) begin
      prod_ff        <= PROD_W'(op_a) * PROD_W'(op_b);
      s2_first_ff    <= s1_first_ff;
      s2_last_ff     <= s1_last_ff;
      s2_dot_ff      <= s1_dot_ff;
      s2_use_seen_ff <= s1_use_seen_ff;
      s2_col_ff      <= s1_col_ff;
   end

   assign acc_base = s2_first_ff ? '0 : acc_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff         <= acc_base + ACC_W'(prod_ff);
         s3_dot_ff      <= s2_dot_ff;
         s3_use_seen_ff <= s2_use_seen_ff;
         s3_col_ff      <= s2_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_wb_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_wb_ff    <= s2_valid_ff && s2_last_ff;
      end
   end

   // floor by the fraction width, then clip to the weight range
   assign acc_shift = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (acc_shift > RES_MAX) begin
         res_val = WEIGHT_W'(RES_MAX);
         res_sat = 1'b1;
      end else if (acc_shift < RES_MIN) begin
         res_val = WEIGHT_W'(RES_MIN);
         res_sat = 1'b1;
      end else begin
         res_val = WEIGHT_W'(acc_shift);
         res_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff        <= 1'b0;
         word_failed_ff <= 1'b0;
         sat_seen_ff    <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (cmd.swap) begin
            bank_ff <= ~bank_ff;
         end
         if (cmd.mark_fail) begin
            word_failed_ff <= 1'b1;
         end else if (cmd.word_begin) begin
            word_failed_ff <= 1'b0;
         end
         if (cmd.word_begin) begin
            sat_seen_ff <= 1'b0;
         end else if (run_we && res_sat) begin
            sat_seen_ff <= 1'b1;
         end
         rsp_strobe_ff <= (s3_wb_ff && s3_dot_ff) || cmd.emit_fail;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fail) begin
         rsp_data_ff.score  <= '0;
         rsp_data_ff.status <= STATUS_BAD_LETTER;
      end else if (s3_wb_ff && s3_dot_ff) begin
         rsp_data_ff.score  <= res_val;
         rsp_data_ff.status <= (res_sat || (s3_use_seen_ff && sat_seen_ff))
                               ? STATUS_SATURATED : STATUS_OK;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
